/* sv/lgs_pkg.sv */
// Shared constants for the life grid generation stepper.
// Grid geometry, field widths, command and register codes.
// No dependencies.
package lgs_pkg;

	localparam int MAX_COLS = 32;
	localparam int MAX_ROWS = 32;

	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int CNT_W   = $clog2(MAX_ROWS + 2);
	localparam int CMD_W   = 2;
	localparam int RIDX_W  = 5;
	localparam int GEN_W   = 16;
	localparam int CFG_W   = 6;
	localparam int CIDX_W  = 1;

	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [CIDX_W-1:0] REG_COLS = 1'd0;
	localparam logic [CIDX_W-1:0] REG_ROWS = 1'd1;

	localparam logic [CFG_W-1:0] CFG_RESET = 6'd17;

	typedef logic [MAX_COLS-1:0] row_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_STEP = 3'b100
	} state_t;

endpackage

/* sv/lgs_if.sv */
// Request channels of the life grid generation stepper.
// Command, result and configuration channels; depends on lgs_pkg.
interface lgs_in_if;
	import lgs_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [RIDX_W-1:0]   row_index;
	logic [31:0]         row_bits;
	logic [GEN_W-1:0]    gen_count;
	modport source (output valid, cmd, row_index, row_bits, gen_count, input ready);
	modport sink   (input valid, cmd, row_index, row_bits, gen_count, output ready);
endinterface

interface lgs_out_if;
	import lgs_pkg::*;
	logic                valid;
	logic                ready;
	logic [31:0]         out_row_bits;
	logic [RIDX_W-1:0]   out_row_index;
	modport source (output valid, out_row_bits, out_row_index, input ready);
	modport sink   (input valid, out_row_bits, out_row_index, output ready);
endinterface

interface lgs_cfg_if;
	import lgs_pkg::*;
	logic                valid;
	logic                ready;
	logic [CIDX_W-1:0]   index;
	logic [CFG_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* sv/life_grid_generation_stepper.sv */
// Life grid stepper: load, read and advance a bounded B3/S23 grid.
// Load, unused command and zero-generation step: result 1 cycle after accept.
// Read: result 2 cycles after accept (registered grid memory read).
// Step of N generations: result N * (rows in use + 2) + 1 cycles after accept, one row
// per cycle through the single grid memory read port and one shared row rule unit.
// No accept while a read or step is in progress. Reset: grid reads all dead, registers 17.
module life_grid_generation_stepper (
	input  logic clk,
	input  logic arst_n,
	lgs_in_if.sink    in_ch,
	lgs_out_if.source out_ch,
	lgs_cfg_if.sink   cfg
);
	import lgs_pkg::*;

	state_t state_q;

	logic [CFG_W-1:0] cols_q, rows_q;
	logic [CFG_W-1:0] cols_act, rows_act;
	row_t             mask;

	row_t              grid_mem [MAX_ROWS];
	logic [MAX_ROWS-1:0] row_vld_q;

	logic              rd_en, rd_hit;
	logic [ROW_W-1:0]  rd_addr;
	row_t              rd_s1;
	logic              rd_hit_s1;
	row_t              rd_row;

	logic              wr_en;
	logic [ROW_W-1:0]  wr_addr;
	row_t              wr_data;

	logic [CNT_W-1:0]  cnt_q;
	logic [GEN_W-1:0]  gen_q;
	row_t              up_q, mid_q, next_row;

	logic              out_valid_q;
	logic [31:0]       out_bits_q;
	logic [RIDX_W-1:0] out_idx_q;

	logic in_acc, step_wr, gen_end, step_start, out_set;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CFG_RESET;
			rows_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_COLS: cols_q <= cfg.data;
				REG_ROWS: rows_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cols_act = cols_q;
		if (cols_q == '0) cols_act = CFG_W'(1);
		else if (cols_q > CFG_W'(MAX_COLS)) cols_act = CFG_W'(MAX_COLS);
		rows_act = rows_q;
		if (rows_q == '0) rows_act = CFG_W'(1);
		else if (rows_q > CFG_W'(MAX_ROWS)) rows_act = CFG_W'(MAX_ROWS);
		for (int j = 0; j < MAX_COLS; j++)
			mask[j] = (CFG_W'(j) < cols_act);
	end

	assign in_ch.ready = (state_q == S_IDLE) && (!out_valid_q || out_ch.ready);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign step_start  = in_acc && (in_ch.cmd == CMD_STEP) && (in_ch.gen_count != '0);
	assign step_wr     = (state_q == S_STEP) && (cnt_q >= CNT_W'(2));
	assign gen_end     = (state_q == S_STEP) && (cnt_q == CNT_W'(rows_act) + CNT_W'(1));
	assign out_set     = (in_acc && (in_ch.cmd != CMD_READ) && !step_start)
		|| (state_q == S_READ) || (gen_end && (gen_q == GEN_W'(1)));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = in_ch.row_index[ROW_W-1:0];
		rd_hit  = 1'b0;
		if (state_q == S_STEP) begin
			rd_addr = cnt_q[ROW_W-1:0];
			rd_hit  = cnt_q < CNT_W'(rows_act);
			rd_en   = rd_hit;
		end else if (in_acc && (in_ch.cmd == CMD_READ)) begin
			rd_en  = 1'b1;
			rd_hit = CFG_W'(in_ch.row_index) < rows_act;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_s1 <= grid_mem[rd_addr];
		if (wr_en)
			grid_mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_hit_s1 <= 1'b0;
		else
			rd_hit_s1 <= rd_en && rd_hit && row_vld_q[rd_addr];
	end

	assign rd_row = rd_hit_s1 ? (rd_s1 & mask) : '0;

	lgs_row_rule u_rule (
		.up      (up_q),
		.mid     (mid_q),
		.dn      (rd_row),
		.mask    (mask),
		.next_row(next_row)
	);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = in_ch.row_index[ROW_W-1:0];
		wr_data = in_ch.row_bits;
		if (step_wr) begin
			wr_en   = 1'b1;
			wr_addr = ROW_W'(cnt_q - CNT_W'(2));
			wr_data = next_row;
		end else if (in_acc && (in_ch.cmd == CMD_LOAD)) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else begin
			if (step_start) begin
				for (int i = 0; i < MAX_ROWS; i++)
					if (CFG_W'(i) >= rows_act) row_vld_q[i] <= 1'b0;
			end
			if (wr_en)
				row_vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_STEP) begin
			if (cnt_q == '0) begin
				up_q  <= '0;
				mid_q <= '0;
			end else begin
				up_q  <= mid_q;
				mid_q <= rd_row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
			out_bits_q  <= '0;
			out_idx_q   <= '0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && !out_ch.ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						out_idx_q <= in_ch.row_index;
						out_bits_q <= '0;
						cnt_q     <= '0;
						gen_q     <= in_ch.gen_count;
						if (in_ch.cmd == CMD_READ)
							state_q <= S_READ;
						else if (step_start)
							state_q <= S_STEP;
					end
				end
				S_READ: begin
					out_bits_q  <= rd_row;
					state_q     <= S_IDLE;
				end
				S_STEP: begin
					if (gen_end) begin
						cnt_q <= '0;
						gen_q <= gen_q - GEN_W'(1);
						if (gen_q == GEN_W'(1)) begin
							out_bits_q  <= '0;
							state_q     <= S_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_row_bits  = out_bits_q;
	assign out_ch.out_row_index = out_idx_q;

endmodule

/* sv/lgs_row_rule.sv */
// Next state of one grid row under rule B3/S23, all columns at once.
// Takes the rows above, at and below; depends on lgs_pkg.
module lgs_row_rule (
	input  lgs_pkg::row_t up,
	input  lgs_pkg::row_t mid,
	input  lgs_pkg::row_t dn,
	input  lgs_pkg::row_t mask,
	output lgs_pkg::row_t next_row
);
	import lgs_pkg::*;

	row_t up_l, up_r, mid_l, mid_r, dn_l, dn_r;
	row_t live;

	assign up_l  = {up[MAX_COLS-2:0], 1'b0};
	assign up_r  = {1'b0, up[MAX_COLS-1:1]};
	assign mid_l = {mid[MAX_COLS-2:0], 1'b0};
	assign mid_r = {1'b0, mid[MAX_COLS-1:1]};
	assign dn_l  = {dn[MAX_COLS-2:0], 1'b0};
	assign dn_r  = {1'b0, dn[MAX_COLS-1:1]};

	always_comb begin
		logic [3:0] cnt;
		live = '0;
		for (int j = 0; j < MAX_COLS; j++) begin
			cnt = {3'b0, up_l[j]} + {3'b0, up[j]} + {3'b0, up_r[j]}
				+ {3'b0, mid_l[j]} + {3'b0, mid_r[j]}
				+ {3'b0, dn_l[j]} + {3'b0, dn[j]} + {3'b0, dn_r[j]};
			live[j] = (cnt == 4'd3) || ((cnt == 4'd2) && mid[j]);
		end
	end

	assign next_row = live & mask;

endmodule

/* sv/lgs_checker.sv */
// Port-level checks for the life grid generation stepper.
// Depends on lgs_pkg; bound to the top level below.
module lgs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [lgs_pkg::CMD_W-1:0] in_cmd,
	input logic [lgs_pkg::RIDX_W-1:0] in_row_index,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [31:0]               out_row_bits,
	input logic [lgs_pkg::RIDX_W-1:0] out_row_index
);
	import lgs_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_row_bits)
			&& $stable(out_row_index))
		else $error("result request dropped or changed while stalled");

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_cmd == CMD_LOAD) |=> out_valid && (out_row_bits == '0)
			&& (out_row_index == $past(in_row_index)))
		else $error("load request did not complete in one cycle");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_cmd == CMD_READ) |=> !in_ready ##1
			(out_valid && (out_row_index == $past(in_row_index, 2))))
		else $error("read request timing wrong");

	a_unused_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_cmd != CMD_LOAD) && (in_cmd != CMD_STEP) && (in_cmd != CMD_READ)
			|=> out_valid && (out_row_bits == '0))
		else $error("unused command gave a non-zero row");

endmodule

bind life_grid_generation_stepper lgs_checker u_lgs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_cmd       (in_ch.cmd),
	.in_row_index (in_ch.row_index),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_row_bits (out_ch.out_row_bits),
	.out_row_index(out_ch.out_row_index)
);
